>>> rtl/assert_macros.svh
// Assertion macros for the RTL files of the square-wave channel.
// No dependencies; with SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under synchronous active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication under synchronous active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sqch_pkg.sv
// Package for the square-wave sound channel: operation codes, register
// indexes, stream widths and small helper functions. No dependencies.
package sqch_pkg;

    localparam int OP_W        = 3;
    localparam int IDX_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int FREQ_W      = 11;
    localparam int PERIOD_W    = 14;
    localparam int VOL_W       = 4;
    localparam int LEN_W       = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_TICK   = 3'd2,
        OP_LENGTH = 3'd3,
        OP_SWEEP  = 3'd4,
        OP_ENV    = 3'd5
    } t_op;

    localparam logic [IDX_W-1:0] REG_SWEEP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DUTY    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ENV     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FREQ_LO = 3'd3;
    localparam logic [IDX_W-1:0] REG_FREQ_HI = 3'd4;

    localparam logic [LEN_W-1:0] LEN_FULL     = 7'd64;
    localparam logic [3:0]       CNT_DEFAULT  = 4'd8;
    localparam logic [VOL_W-1:0] VOL_MAX      = 4'd15;

    // Duty waveforms, MSB is step 0.
    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
        logic [7:0] wave;
        case (sel)
            2'd0:    wave = 8'h01;
            2'd1:    wave = 8'h81;
            2'd2:    wave = 8'h87;
            default: wave = 8'h7E;
        endcase
        return wave[3'd7 - step];
    endfunction

    // Timer reload: (2048 - f) * 4.
    function automatic logic [PERIOD_W-1:0] period_reload(input logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] span;
        span = 12'd2048 - {1'b0, f};
        return {span, 2'b00};
    endfunction

    // Sweep target; bit 11 set means overflow past 2047.
    function automatic logic [FREQ_W:0] sweep_calc(input logic [FREQ_W-1:0] f,
                                                   input logic [2:0] shift,
                                                   input logic sub);
        logic [FREQ_W:0] delta;
        delta = {1'b0, f >> shift};
        return sub ? ({1'b0, f} - delta) : ({1'b0, f} + delta);
    endfunction

endpackage

>>> rtl/square_wave_sound_channel_top.sv
// Top level of the square-wave sound channel (sweep, envelope, length).
// Depends on sqch_pkg and assert_macros.svh.
//
// Usage:
//   Slave stream carries one operation per item: tuser = op (write, read,
//   timer tick, length clock, sweep clock, envelope clock), tdata holds
//   reg_index in [2:0] and write_data in [10:3].
//   Master stream returns exactly one item per input item: tdata holds
//   read_data [7:0], output_level [11:8], channel_on [12],
//   length_running [13]; bits [15:14] are zero.
//   Path: an accepted item is held in the input register, then the update
//   logic computes its result into the result register, which drives the
//   master stream.
//   Throughput: one item per clock while the receiver takes results. The
//   channel state updates in a single pass of short logic per item, so
//   consecutive items chain through the state register with no bubble.
//   Reset (i_rst_n low, synchronous) clears all channel state and both
//   stage valids; the first item may be offered on the cycle after.
//   When the receiver stalls, the result register holds; the input
//   register takes one more item, and then s_axis_tready drops until the
//   result is taken.
`include "assert_macros.svh"
module square_wave_sound_channel_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sqch_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // reg_index, write_data
    input  logic [sqch_pkg::OP_W-1:0]           s_axis_tuser,   // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sqch_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // read_data, output_level,
                                                                // channel_on, length_running
);
    import sqch_pkg::*;

    // Input stage
    logic              r_in_vld;
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_wdata;

    // Result stage
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Channel registers
    logic [2:0]          r_sweep_per, n_sweep_per;
    logic                r_sweep_sub, n_sweep_sub;
    logic [2:0]          r_sweep_shift, n_sweep_shift;
    logic [1:0]          r_duty, n_duty;
    logic [5:0]          r_len_reload, n_len_reload;
    logic [LEN_W-1:0]    r_len_left, n_len_left;
    logic [VOL_W-1:0]    r_vol_init, n_vol_init;
    logic                r_env_inc, n_env_inc;
    logic [2:0]          r_env_per, n_env_per;
    logic [FREQ_W-1:0]   r_freq, n_freq;
    logic                r_len_gate, n_len_gate;
    logic                r_trig, n_trig;
    logic                r_enabled, n_enabled;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [2:0]          r_step, n_step;
    logic [VOL_W-1:0]    r_vol, n_vol;
    logic [3:0]          r_env_cnt, n_env_cnt;
    logic                r_env_act, n_env_act;
    logic [FREQ_W-1:0]   r_shadow, n_shadow;
    logic [3:0]          r_sweep_cnt, n_sweep_cnt;
    logic [VOL_W-1:0]    r_level, n_level;
    logic [BYTE_W-1:0]   n_rd;

    logic              adv;
    logic [FREQ_W-1:0] freq_trig;
    logic [FREQ_W:0]   trig_nf, sw_nf1, sw_nf2;
    logic [3:0]        sweep_rl, env_rl;
    logic [VOL_W-1:0]  vol_step;

    // Stage handshake: input register moves on when the result slot is free
    // or being emptied this cycle.
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= s_axis_tuser;
            r_idx   <= s_axis_tdata[IDX_W-1:0];
            r_wdata <= s_axis_tdata[IDX_W +: BYTE_W];
        end
    end

    // Helper values for the update logic
    assign freq_trig = {r_wdata[2:0], r_freq[7:0]};
    assign trig_nf   = sweep_calc(freq_trig, r_sweep_shift, r_sweep_sub);
    assign sw_nf1    = sweep_calc(r_shadow, r_sweep_shift, r_sweep_sub);
    assign sw_nf2    = sweep_calc(sw_nf1[FREQ_W-1:0], r_sweep_shift, r_sweep_sub);
    assign sweep_rl  = (r_sweep_per != 3'd0) ? {1'b0, r_sweep_per} : CNT_DEFAULT;
    assign env_rl    = (r_env_per != 3'd0) ? {1'b0, r_env_per} : CNT_DEFAULT;
    // Envelope step saturates at both ends
    assign vol_step  = r_env_inc ? ((r_vol < VOL_MAX) ? r_vol + 4'd1 : r_vol)
                                 : ((r_vol != 4'd0) ? r_vol - 4'd1 : r_vol);

    always_comb begin
        n_sweep_per   = r_sweep_per;
        n_sweep_sub   = r_sweep_sub;
        n_sweep_shift = r_sweep_shift;
        n_duty        = r_duty;
        n_len_reload  = r_len_reload;
        n_len_left    = r_len_left;
        n_vol_init    = r_vol_init;
        n_env_inc     = r_env_inc;
        n_env_per     = r_env_per;
        n_freq        = r_freq;
        n_len_gate    = r_len_gate;
        n_trig        = r_trig;
        n_enabled     = r_enabled;
        n_period      = r_period;
        n_step        = r_step;
        n_vol         = r_vol;
        n_env_cnt     = r_env_cnt;
        n_env_act     = r_env_act;
        n_shadow      = r_shadow;
        n_sweep_cnt   = r_sweep_cnt;
        n_level       = r_level;
        n_rd          = '0;
        case (t_op'(r_op))
            OP_WRITE: begin
                case (r_idx)
                    REG_SWEEP: begin
                        n_sweep_shift = r_wdata[2:0];
                        n_sweep_sub   = r_wdata[3];
                        n_sweep_per   = r_wdata[6:4];
                    end
                    REG_DUTY: begin
                        n_len_reload = r_wdata[5:0];
                        n_len_left   = LEN_FULL - {1'b0, r_wdata[5:0]};
                        n_duty       = r_wdata[7:6];
                    end
                    REG_ENV: begin
                        n_vol_init = r_wdata[7:4];
                        n_env_inc  = r_wdata[3];
                        n_env_per  = r_wdata[2:0];
                        n_vol      = r_wdata[7:4];
                    end
                    REG_FREQ_LO: begin
                        n_freq = {r_freq[10:8], r_wdata};
                    end
                    REG_FREQ_HI: begin
                        n_len_gate = r_wdata[6];
                        n_freq     = freq_trig;
                        n_trig     = r_wdata[7];
                        if (r_wdata[7]) begin
                            // trigger restarts envelope, timer and sweep; length reloads only if expired
                            n_enabled = 1'b1;
                            if (r_len_left == '0) begin
                                n_len_left = LEN_FULL;
                            end
                            n_env_act   = 1'b1;
                            n_env_cnt   = {1'b0, r_env_per};
                            n_vol       = r_vol_init;
                            n_period    = period_reload(freq_trig);
                            n_shadow    = freq_trig;
                            n_sweep_cnt = sweep_rl;
                            if (r_sweep_shift != 3'd0 && trig_nf[FREQ_W]) begin
                                n_enabled = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                case (r_idx)
                    REG_SWEEP:   n_rd = {1'b0, r_sweep_per, r_sweep_sub, r_sweep_shift};
                    REG_DUTY:    n_rd = {r_duty, r_len_reload};
                    REG_ENV:     n_rd = {r_vol_init, r_env_inc, r_env_per};
                    REG_FREQ_LO: n_rd = r_freq[7:0];
                    REG_FREQ_HI: n_rd = {r_trig, r_len_gate, 3'b000, r_freq[10:8]};
                    default:     n_rd = '0;
                endcase
            end
            OP_TICK: begin
                if (r_period <= 14'd1) begin
                    n_period = period_reload(r_freq);
                    n_step   = r_step + 3'd1;
                end else begin
                    n_period = r_period - 14'd1;
                end
                n_level = (r_enabled && duty_bit(r_duty, n_step)) ? r_vol : '0;
            end
            OP_LENGTH: begin
                if (r_len_gate && r_len_left != '0) begin
                    n_len_left = r_len_left - 7'd1;
                    if (r_len_left == 7'd1) begin
                        n_enabled = 1'b0;
                    end
                end
            end
            OP_SWEEP: begin
                if (r_sweep_cnt <= 4'd1) begin
                    n_sweep_cnt = sweep_rl;
                    if (r_sweep_per != 3'd0) begin
                        if (sw_nf1[FREQ_W]) begin
                            n_enabled = 1'b0;
                        end else if (r_sweep_shift != 3'd0) begin
                            n_shadow = sw_nf1[FREQ_W-1:0];
                            n_freq   = sw_nf1[FREQ_W-1:0];
                            // second pass only checks overflow
                            if (sw_nf2[FREQ_W]) begin
                                n_enabled = 1'b0;
                            end
                        end
                    end
                end else begin
                    n_sweep_cnt = r_sweep_cnt - 4'd1;
                end
            end
            OP_ENV: begin
                if (r_env_cnt <= 4'd1) begin
                    n_env_cnt = env_rl;
                    if (r_env_per != 3'd0 && r_env_act) begin
                        n_vol = vol_step;
                        if (vol_step == '0 || vol_step == VOL_MAX) begin
                            n_env_act = 1'b0;
                        end
                    end
                end else begin
                    n_env_cnt = r_env_cnt - 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Channel state commits when the item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_per   <= '0;
            r_sweep_sub   <= 1'b0;
            r_sweep_shift <= '0;
            r_duty        <= '0;
            r_len_reload  <= '0;
            r_len_left    <= '0;
            r_vol_init    <= '0;
            r_env_inc     <= 1'b0;
            r_env_per     <= '0;
            r_freq        <= '0;
            r_len_gate    <= 1'b0;
            r_trig        <= 1'b0;
            r_enabled     <= 1'b0;
            r_period      <= '0;
            r_step        <= '0;
            r_vol         <= '0;
            r_env_cnt     <= '0;
            r_env_act     <= 1'b0;
            r_shadow      <= '0;
            r_sweep_cnt   <= '0;
            r_level       <= '0;
        end else if (adv) begin
            r_sweep_per   <= n_sweep_per;
            r_sweep_sub   <= n_sweep_sub;
            r_sweep_shift <= n_sweep_shift;
            r_duty        <= n_duty;
            r_len_reload  <= n_len_reload;
            r_len_left    <= n_len_left;
            r_vol_init    <= n_vol_init;
            r_env_inc     <= n_env_inc;
            r_env_per     <= n_env_per;
            r_freq        <= n_freq;
            r_len_gate    <= n_len_gate;
            r_trig        <= n_trig;
            r_enabled     <= n_enabled;
            r_period      <= n_period;
            r_step        <= n_step;
            r_vol         <= n_vol;
            r_env_cnt     <= n_env_cnt;
            r_env_act     <= n_env_act;
            r_shadow      <= n_shadow;
            r_sweep_cnt   <= n_sweep_cnt;
            r_level       <= n_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {2'b00, (n_len_left != '0), n_enabled, n_level, n_rd};
        end
    end

    `ASSERT_IMPLIES(a_len_range, i_clk, i_rst_n, 1'b1, r_len_left <= LEN_FULL)
    `ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, 1'b1,
                    r_env_cnt <= CNT_DEFAULT && r_sweep_cnt <= CNT_DEFAULT)
    `ASSERT_IMPLIES(a_period_range, i_clk, i_rst_n, 1'b1, r_period <= 14'd8192)
    `ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !adv, r_in_vld)
    `ASSERT_NEXT(a_len_expiry, i_clk, i_rst_n,
                 adv && r_op == OP_LENGTH && r_len_gate && r_len_left == 7'd1,
                 !r_enabled && r_len_left == '0)

endmodule
